/* rtl/rkcce_pkg.sv */
// Shared types and constants for the RGB kernel convolution block.
package rkcce_pkg;

    localparam int PIX_W  = 8;                 // one colour channel
    localparam int RGB_W  = 3 * PIX_W;         // packed pixel, red high, blue low
    localparam int COEF_W = 16;                // signed Q2.14 coefficient
    localparam int PROD_W = COEF_W + PIX_W + 1; // coefficient times unsigned channel
    localparam int CRD_W  = 11;                // signed working coordinate
    localparam int CFG_W  = 9;                 // widest config register

    typedef enum logic [1:0] {
        OP_COEF  = 2'd0,
        OP_PIXEL = 2'd1,
        OP_CONV  = 2'd2
    } opcode_t;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // control from the window sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;   // start of a new window: zero the sums
        logic valid;   // memory read data is a window tap this cycle
    } mac_ctl_t;

endpackage

/* rtl/rkcce_mac.sv */
// Three-lane multiply-accumulate unit with truncate and saturate to 0..255.
module rkcce_mac #(
    parameter int ACC_W          = 32,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  rkcce_pkg::mac_ctl_t             ctl,
    input  logic signed [rkcce_pkg::COEF_W-1:0] coef,
    input  logic [rkcce_pkg::RGB_W-1:0]     pix,
    output logic                            busy,
    output logic [rkcce_pkg::RGB_W-1:0]     rgb_out   // blue [7:0], green [15:8], red [23:16]
);
    import rkcce_pkg::*;

    localparam int EXT_W = ACC_W + PIX_W + 1;

    logic signed [PROD_W-1:0] prod_reg [3];
    logic                     prod_vld_reg;
    logic signed [ACC_W-1:0]  acc_reg  [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= ctl.valid;
        end
    end

    // lane 0 is blue (low byte), lane 2 is red
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            prod_reg[i] <= PROD_W'(coef) * PROD_W'($signed({1'b0, pix[i*PIX_W +: PIX_W]}));
            if (ctl.clear) begin
                acc_reg[i] <= '0;
            end else if (prod_vld_reg) begin
                acc_reg[i] <= acc_reg[i]
                    + {{(ACC_W-PROD_W){prod_reg[i][PROD_W-1]}}, prod_reg[i]};
            end
        end
    end

    assign busy = prod_vld_reg;

    always_comb begin
        logic signed [EXT_W-1:0] ext;
        logic signed [EXT_W-1:0] shr;
        for (int i = 0; i < 3; i++) begin
            ext = {{(EXT_W-ACC_W){acc_reg[i][ACC_W-1]}}, acc_reg[i]};
            shr = ext >>> COEF_FRAC_BITS;
            if (acc_reg[i][ACC_W-1] || acc_reg[i] == '0) begin
                rgb_out[i*PIX_W +: PIX_W] = '0;
            end else if (shr[EXT_W-1:PIX_W] != '0) begin
                rgb_out[i*PIX_W +: PIX_W] = '1;
            end else begin
                rgb_out[i*PIX_W +: PIX_W] = shr[PIX_W-1:0];
            end
        end
    end

endmodule

/* rtl/rgb_kernel_convolution_clamp_edge.sv */
// Top level: RGB square-kernel convolution with clamp-to-edge sampling.
//
//  channel  direction  handshake         payload
//  s_       in         s_tvalid/tready   s_tdata (64), s_tuser (2) opcode
//  m_       out        m_tvalid/tready   m_tdata (24), m_tuser (1) out_of_bounds
//  cfg_     in         cfg_wr_en         cfg_addr (2), cfg_wdata (9)
//
// Coefficient loads and pixel writes are stored as they are accepted and leave the block idle.
// A compute walks the (2r+1)^2 window one tap per cycle through the single frame
// memory read port; its result reaches the output register through the run, drain and
// done states, or straight from done outside the image. s_tready is low from a compute's
// acceptance until its result is in the output register; a held result does not stall loads or writes.
// Synchronous active-low reset clears control and sets radius 1, width 256 and height 256; both memories start unknown.
module rgb_kernel_convolution_clamp_edge #(
    parameter int MAX_WIDTH      = 256,
    parameter int MAX_HEIGHT     = 256,
    parameter int MAX_RADIUS     = 5,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // pos_x[7:0] pos_y[15:8] in_red[23:16] in_green[31:24] in_blue[39:32]
    // coef_index[46:40] coef_value[62:47], bit 63 zero
    input  logic [63:0]                   s_tdata,
    input  logic [1:0]                    s_tuser,   // opcode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [23:0]                   m_tdata,   // out_red[7:0] out_green[15:8] out_blue[23:16]
    output logic                          m_tuser,   // out_of_bounds
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_addr,
    input  logic [rkcce_pkg::CFG_W-1:0]   cfg_wdata
);
    import rkcce_pkg::*;

    localparam int SPAN_MAX    = 2 * MAX_RADIUS + 1;
    localparam int COEF_DEPTH  = SPAN_MAX * SPAN_MAX;
    localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int CI_W        = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
    localparam int FA_W        = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int RAD_W       = $clog2(MAX_RADIUS + 1) + 1;
    localparam int ACC_W       = PROD_W + CI_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    // input fields
    opcode_t                  op;
    logic [PIX_W-1:0]         in_x, in_y;
    logic [RGB_W-1:0]         in_rgb;
    logic [6:0]               in_ci;
    logic signed [COEF_W-1:0] in_coef;

    assign op      = opcode_t'(s_tuser);
    assign in_x    = s_tdata[7:0];
    assign in_y    = s_tdata[15:8];
    assign in_rgb  = {s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]};
    assign in_ci   = s_tdata[46:40];
    assign in_coef = s_tdata[62:47];

    // configuration
    logic [2:0]       radius_reg;
    logic [CFG_W-1:0] width_reg, height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= 3'd1;
            width_reg  <= CFG_W'(256);
            height_reg <= CFG_W'(256);
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_RADIUS: radius_reg <= cfg_wdata[2:0];
                REG_WIDTH:  width_reg  <= cfg_wdata;
                REG_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic signed [RAD_W-1:0] r_eff;
    logic signed [CRD_W-1:0] w_eff, h_eff;

    always_comb begin
        r_eff = (32'(radius_reg) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(radius_reg);
        if (width_reg == '0)                 w_eff = CRD_W'(1);
        else if (32'(width_reg) > MAX_WIDTH) w_eff = CRD_W'(MAX_WIDTH);
        else                                 w_eff = CRD_W'(width_reg);
        if (height_reg == '0)                  h_eff = CRD_W'(1);
        else if (32'(height_reg) > MAX_HEIGHT) h_eff = CRD_W'(MAX_HEIGHT);
        else                                   h_eff = CRD_W'(height_reg);
    end

    // sequencer
    state_t                  state_reg, state_next;
    logic signed [RAD_W-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [CI_W-1:0]         ci_reg, ci_next;
    logic [PIX_W-1:0]        x_reg, x_next, y_reg, y_next;
    logic                    oob_reg, oob_next;
    logic                    rd_vld_reg;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [RGB_W-1:0]        m_tdata_reg, m_tdata_next;
    logic                    m_tuser_reg, m_tuser_next;

    logic                    s_acc, issue, out_free, mac_busy;
    mac_ctl_t                mac_ctl;
    logic [RGB_W-1:0]        mac_rgb;

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign issue    = (state_reg == S_RUN);
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next    = state_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        ci_next       = ci_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        oob_next      = oob_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        mac_ctl.clear = 1'b0;
        mac_ctl.valid = rd_vld_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_acc && op == OP_CONV) begin
                    x_next        = in_x;
                    y_next        = in_y;
                    dx_next       = -r_eff;
                    dy_next       = -r_eff;
                    ci_next       = '0;
                    mac_ctl.clear = 1'b1;
                    oob_next      = (CRD_W'(in_x) >= w_eff) || (CRD_W'(in_y) >= h_eff);
                    state_next    = oob_next ? S_DONE : S_RUN;
                end
            end
            S_RUN: begin
                ci_next = ci_reg + 1'b1;
                if (dx_reg == r_eff) begin
                    dx_next = -r_eff;
                    dy_next = dy_reg + 1'b1;
                    if (dy_reg == r_eff) state_next = S_DRAIN;
                end else begin
                    dx_next = dx_reg + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!rd_vld_reg && !mac_busy) state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = oob_reg ? '0 :
                        {mac_rgb[7:0], mac_rgb[15:8], mac_rgb[23:16]};
                    m_tuser_next  = oob_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_vld_reg   <= issue;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        ci_reg      <= ci_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        oob_reg     <= oob_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // clamp-to-edge tap address
    logic signed [CRD_W-1:0] px, py, px_c, py_c;
    logic [FA_W-1:0]         rd_addr, wr_addr;

    always_comb begin
        px = $signed(CRD_W'(x_reg)) + CRD_W'(dx_reg);
        py = $signed(CRD_W'(y_reg)) + CRD_W'(dy_reg);
        if (px < 0)              px_c = '0;
        else if (px > w_eff - 1) px_c = w_eff - 1'b1;
        else                     px_c = px;
        if (py < 0)              py_c = '0;
        else if (py > h_eff - 1) py_c = h_eff - 1'b1;
        else                     py_c = py;
        rd_addr = FA_W'(py_c) * FA_W'(MAX_WIDTH) + FA_W'(px_c);
        wr_addr = FA_W'(in_y) * FA_W'(MAX_WIDTH) + FA_W'(in_x);
    end

    // memories
    logic [RGB_W-1:0]         frame_mem [FRAME_DEPTH];
    logic signed [COEF_W-1:0] coef_mem  [COEF_DEPTH];
    logic [RGB_W-1:0]         pix_rd_reg;
    logic signed [COEF_W-1:0] coef_rd_reg;
    logic                     pix_we, coef_we;

    assign pix_we  = s_acc && op == OP_PIXEL
                     && 32'(in_x) < MAX_WIDTH && 32'(in_y) < MAX_HEIGHT;
    assign coef_we = s_acc && op == OP_COEF && 32'(in_ci) < COEF_DEPTH;

    always_ff @(posedge aclk) begin
        if (pix_we) frame_mem[wr_addr] <= in_rgb;
        pix_rd_reg <= frame_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (coef_we) coef_mem[CI_W'(in_ci)] <= in_coef;
        coef_rd_reg <= coef_mem[ci_reg];
    end

    rkcce_mac #(
        .ACC_W          (ACC_W),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .coef    (coef_rd_reg),
        .pix     (pix_rd_reg),
        .busy    (mac_busy),
        .rgb_out (mac_rgb)
    );

endmodule

/* tb/rgb_kernel_convolution_clamp_edge_tb.sv */
// Self-checking testbench for the clamp-to-edge RGB kernel convolution block.
module rgb_kernel_convolution_clamp_edge_tb;
    import rkcce_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int MAX_W        = 256;
    localparam int MAX_H        = 256;
    localparam int MAX_R        = 5;
    localparam int FRAC_BITS    = 14;
    localparam int COEF_DEPTH   = (2 * MAX_R + 1) * (2 * MAX_R + 1);
    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 1000;
    localparam int DRAIN_CYCLES = 150;
    localparam int CFG_SETTLE   = 8;
    localparam int PHASE_ITEMS  = 20;
    localparam int REPORT_MAX   = 10;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       oob;
    } conv_result_t;

    typedef enum int {KERN_BLUR, KERN_FULL, KERN_SIGNED} kern_style_t;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [63:0]       s_tdata;   // pos_x, pos_y, in_red, in_green, in_blue, coef_index, coef_value
    logic [1:0]        s_tuser;   // opcode
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [23:0]       m_tdata;   // out_red, out_green, out_blue
    logic              m_tuser;   // out_of_bounds
    logic              cfg_wr_en;
    logic [1:0]        cfg_addr;
    logic [CFG_W-1:0]  cfg_wdata;

    // shadow of the block's stores and registers
    logic [23:0]        frame_mem [0:MAX_W*MAX_H-1];
    bit                 frame_set [0:MAX_W*MAX_H-1];
    logic signed [15:0] coef_mem  [0:COEF_DEPTH-1];
    bit                 coef_set  [0:COEF_DEPTH-1];
    logic [2:0]         radius_reg;
    logic [8:0]         width_reg;
    logic [8:0]         height_reg;

    conv_result_t expected_pixels[$];
    kern_style_t  kern_style;
    int fault_count  = 0;
    int report_count = 0;
    int items_sent   = 0;
    int src_idle_pct;
    int sink_idle_pct;
    int hold_left    = 0;
    int quiet_cycles = 0;
    bit hold_toggle;
    bit hold_seen    = 1'b0;

    rgb_kernel_convolution_clamp_edge dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    function automatic int eff_radius();
        return (radius_reg > MAX_R) ? MAX_R : radius_reg;
    endfunction

    function automatic int eff_width();
        if (width_reg == 0) return 1;
        return (width_reg > MAX_W) ? MAX_W : width_reg;
    endfunction

    function automatic int eff_height();
        if (height_reg == 0) return 1;
        return (height_reg > MAX_H) ? MAX_H : height_reg;
    endfunction

    function automatic int clamp_coord(int v, int hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    // drop the fraction bits, negatives go to zero, saturate at full scale
    function automatic logic [7:0] channel_sat(longint acc);
        longint v;
        if (acc <= 0) return 8'd0;
        v = acc >>> FRAC_BITS;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic conv_result_t predict_conv(int x, int y);
        conv_result_t res;
        int r, w, h, span, addr;
        longint acc_r, acc_g, acc_b, c;
        logic [23:0] pix;
        r = eff_radius();
        w = eff_width();
        h = eff_height();
        span = 2 * r + 1;
        res = '{8'd0, 8'd0, 8'd0, 1'b1};
        if (x >= w || y >= h) return res;
        acc_r = 0;
        acc_g = 0;
        acc_b = 0;
        for (int dy = -r; dy <= r; dy++) begin
            for (int dx = -r; dx <= r; dx++) begin
                addr = clamp_coord(y + dy, h - 1) * MAX_W + clamp_coord(x + dx, w - 1);
                pix = frame_mem[addr];
                c = coef_mem[(dy + r) * span + dx + r];
                acc_r += c * longint'(pix[23:16]);
                acc_g += c * longint'(pix[15:8]);
                acc_b += c * longint'(pix[7:0]);
            end
        end
        res.red   = channel_sat(acc_r);
        res.green = channel_sat(acc_g);
        res.blue  = channel_sat(acc_b);
        res.oob   = 1'b0;
        return res;
    endfunction

    function automatic logic [15:0] pick_coef();
        int share;
        share = 16384 / ((2 * eff_radius() + 1) * (2 * eff_radius() + 1));
        case (kern_style)
            KERN_BLUR:   return 16'($urandom_range(0, 2 * share - 1));
            KERN_SIGNED: return 16'($urandom_range(0, 3 * share - 1) - share);
            default:     return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // offer one item, hold it until the transaction completes, then update the shadow
    task automatic send_item(logic [1:0] opc, logic [7:0] x, y, red, green, blue,
                             logic [6:0] idx, logic [15:0] val);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= opc;
        s_tdata  <= {1'b0, val, idx, blue, green, red, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        case (opc)
            OP_COEF: begin
                if (idx < COEF_DEPTH) begin
                    coef_mem[idx] = val;
                    coef_set[idx] = 1'b1;
                    items_sent++;
                end
            end
            OP_PIXEL: begin
                frame_mem[{y, x}] = {red, green, blue};
                frame_set[{y, x}] = 1'b1;
                items_sent++;
            end
            OP_CONV: begin
                expected_pixels.push_back(predict_conv(x, y));
                items_sent++;
            end
            default: ;
        endcase
    endtask

    task automatic load_coef(int idx, logic [15:0] val);
        send_item(OP_COEF, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 7'(idx), val);
    endtask

    task automatic write_pixel(int x, int y, logic [23:0] rgb);
        send_item(OP_PIXEL, 8'(x), 8'(y), rgb[23:16], rgb[15:8], rgb[7:0],
                  7'($urandom), 16'($urandom));
    endtask

    // fills any coefficient or window pixel not yet written, so nothing unknown is read
    task automatic request_conv(int x, int y);
        int r, w, h, span, px, py;
        r = eff_radius();
        w = eff_width();
        h = eff_height();
        span = 2 * r + 1;
        if (x < w && y < h) begin
            for (int i = 0; i < span * span; i++)
                if (!coef_set[i]) load_coef(i, pick_coef());
            for (int dy = -r; dy <= r; dy++) begin
                for (int dx = -r; dx <= r; dx++) begin
                    px = clamp_coord(x + dx, w - 1);
                    py = clamp_coord(y + dy, h - 1);
                    if (!frame_set[py * MAX_W + px]) write_pixel(px, py, 24'($urandom));
                end
            end
        end
        send_item(OP_CONV, 8'(x), 8'(y), 8'($urandom), 8'($urandom), 8'($urandom),
                  7'($urandom), 16'($urandom));
    endtask

    // registers change only once the block has drained
    task automatic set_geometry(int r, int w, int h);
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (CFG_SETTLE) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_RADIUS;
        cfg_wdata <= {6'($urandom), 3'(r)};   // upper bits are don't-care
        @(posedge aclk);
        radius_reg = r[2:0];
        cfg_addr  <= REG_WIDTH;
        cfg_wdata <= w[8:0];
        @(posedge aclk);
        width_reg = w[8:0];
        cfg_addr  <= REG_HEIGHT;
        cfg_wdata <= h[8:0];
        @(posedge aclk);
        height_reg = h[8:0];
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_defaults();
        kern_style = KERN_BLUR;
        write_pixel(255, 255, 24'hFFFFFF);
        write_pixel(254, 254, 24'h000000);
        request_conv(255, 255);
        request_conv(0, 0);
    endtask

    task automatic test_special_cases();
        send_item(OP_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 7'($urandom), 16'($urandom));
        load_coef(127, 16'($urandom));
        load_coef(COEF_DEPTH, 16'($urandom));
        // zero width behaves as one column
        set_geometry(0, 0, 4);
        load_coef(0, 16'sd16384);
        write_pixel(0, 2, 24'h80FF01);
        request_conv(0, 2);
        load_coef(0, 16'h8000);
        request_conv(0, 2);
        load_coef(0, 16'h7FFF);
        request_conv(0, 2);
        request_conv(1, 0);
        request_conv(0, 4);
        request_conv(255, 255);
        // outside the image but inside the store: must be kept
        write_pixel(200, 3, 24'($urandom));
    endtask

    task automatic test_random_phases();
        int phase_cfg [0:8][0:2] = '{'{0, 1, 1}, '{1, 8, 6}, '{2, 256, 256},
                                     '{7, 3, 2}, '{3, 0, 9}, '{1, 511, 3},
                                     '{4, 10, 256}, '{0, 256, 1}, '{2, 16, 16}};
        int w, h, n, x, y, pick, mark, x0, y0, rw, rh;
        for (int p = 0; p < 9; p++) begin
            set_geometry(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2]);
            src_idle_pct  <= (p == 2) ? 0 : 33;
            sink_idle_pct <= (p == 2) ? 0 : 33;
            kern_style = kern_style_t'($urandom_range(0, 2));
            w = eff_width();
            h = eff_height();
            n = (2 * eff_radius() + 1) * (2 * eff_radius() + 1);
            rw = (w < 8) ? w : 8;
            rh = (h < 8) ? h : 8;
            // a small patch keeps window fills cheap on large images
            case ($urandom_range(0, 2))
                0: begin x0 = 0; y0 = 0; end
                1: begin x0 = w - rw; y0 = h - rh; end
                default: begin
                    x0 = $urandom_range(0, w - rw);
                    y0 = $urandom_range(0, h - rh);
                end
            endcase
            // refresh part of the kernel, always filling entries never loaded
            for (int i = 0; i < n; i++)
                if (!coef_set[i] || $urandom_range(0, 3) == 0) load_coef(i, pick_coef());
            mark = items_sent;
            for (int ops = 0; ops < 10 || items_sent - mark < PHASE_ITEMS; ops++) begin
                pick = $urandom_range(0, 99);
                x = x0 + $urandom_range(0, rw - 1);
                y = y0 + $urandom_range(0, rh - 1);
                if (pick < 45) begin
                    if ($urandom_range(0, 6) == 0) begin
                        if (w < MAX_W) x = $urandom_range(w, 255);
                        else if (h < MAX_H) y = $urandom_range(h, 255);
                    end
                    request_conv(x, y);
                end else if (pick < 75) begin
                    if ($urandom_range(0, 9) < 3)
                        write_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                                    24'($urandom));
                    else
                        write_pixel(x, y, 24'($urandom));
                end else if (pick < 92) begin
                    if ($urandom_range(0, 4) == 0)
                        load_coef($urandom_range(0, 127), 16'($urandom_range(0, 65535)));
                    else
                        load_coef($urandom_range(0, n - 1), pick_coef());
                end else begin
                    send_item(OP_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom),
                              8'($urandom), 8'($urandom), 7'($urandom), 16'($urandom));
                end
            end
        end
        src_idle_pct  <= 33;
        sink_idle_pct <= 33;
    endtask

    // sink holds off while computes keep arriving, so the block backs up its input
    task automatic test_backpressure();
        set_geometry(1, 4, 4);
        kern_style = KERN_SIGNED;
        for (int y = 0; y < 4; y++)
            for (int x = 0; x < 4; x++)
                write_pixel(x, y, 24'($urandom));
        for (int i = 0; i < 9; i++) load_coef(i, pick_coef());
        hold_toggle <= ~hold_toggle;
        for (int k = 0; k < 8; k++) request_conv($urandom_range(0, 3), $urandom_range(0, 3));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_seen <= hold_toggle;
        end else if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    always @(posedge aclk) begin
        conv_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                fault_count++;
                if (report_count < REPORT_MAX)
                    $display("unexpected result at %0t: r=%0d g=%0d b=%0d oob=%0d",
                             $time, m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tuser);
                report_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (m_tdata[7:0] !== want.red || m_tdata[15:8] !== want.green ||
                    m_tdata[23:16] !== want.blue || m_tuser !== want.oob) begin
                    fault_count++;
                    if (report_count < REPORT_MAX)
                        $display({"mismatch at %0t: expected r=%0d g=%0d b=%0d oob=%0d,",
                                  " got r=%0d g=%0d b=%0d oob=%0d"}, $time,
                                 want.red, want.green, want.blue, want.oob,
                                 m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tuser);
                    report_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("rgb_kernel_convolution_clamp_edge_tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn       <= 1'b0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        s_tuser       <= OP_COEF;
        cfg_wr_en     <= 1'b0;
        cfg_addr      <= REG_RADIUS;
        cfg_wdata     <= '0;
        src_idle_pct  <= 33;
        sink_idle_pct <= 33;
        hold_toggle   <= 1'b0;
        kern_style = KERN_BLUR;
        radius_reg = 3'd1;
        width_reg  = 9'd256;
        height_reg = 9'd256;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_defaults();
        test_special_cases();
        test_random_phases();
        test_backpressure();

        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fault_count == 0)
            $display("rgb_kernel_convolution_clamp_edge_tb: clean");
        else
            $display("rgb_kernel_convolution_clamp_edge_tb: errors");
        $finish;
    end

endmodule
